// ===== rtl/cdq_pkg.sv =====
// cdq_pkg: shared types, codes and constants of the circular deque
// used by every module of the block but cdq_ram; depends on nothing
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int WORD_W        = 32;
   localparam int FILL_W        = 5;

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [WORD_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [WORD_W-1:0]  popped_value;
      logic [FILL_W-1:0]         fill_count;
      logic                      is_empty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_direct;
      logic load_read;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;
      logic out_valid;
   } dp_stat_type;

endpackage

// ===== rtl/cdq_ram.sv =====
// cdq_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cdq_ctrl.sv =====
// cdq_ctrl: sequencing state machine of the circular deque
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output logic         req_stall,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      out_free;

   // output register can take a new beat
   assign out_free = !stat.out_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free && stat.needs_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = !out_free;
            cmd.accept      = req_valid && out_free;
            cmd.load_direct = req_valid && out_free && !stat.needs_read;
         end
         ST_READ: begin
            cmd.load_read = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/cdq_dp.sv =====
// cdq_dp: deque datapath - head/tail indices, occupancy, ring store, result register
// depends on cdq_pkg and cdq_ram
`timescale 1ns / 1ps

module cdq_dp
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req,
   input  ctrl_cmd_type cmd,
   input  logic         rsp_stall,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             do_write, do_read;
   logic             is_full, is_none;
   status_type       op_status;
   logic [WORD_W-1:0] rd_data;

   // fill count is the low bits of the occupancy, zero extended when narrower
   logic [CNT_W+FILL_W-1:0] occ_in_wide, occ_ff_wide;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - IDX_W'(1);

   assign is_full = (occ_ff == FULL_CNT);
   assign is_none = (occ_ff == '0);

   always_comb begin
      op_status = STAT_DONE;
      do_write  = 1'b0;
      do_read   = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      case (req.kind)
         KIND_PUSH_BACK: begin
            if (is_full) begin
               op_status = STAT_FULL;
            end else begin
               do_write = 1'b1;
               wr_addr  = tail_ff;
               tail_in  = tail_inc;
               occ_in   = occ_ff + CNT_W'(1);
            end
         end
         KIND_PUSH_FRONT: begin
            if (is_full) begin
               op_status = STAT_FULL;
            end else begin
               do_write = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               occ_in   = occ_ff + CNT_W'(1);
            end
         end
         KIND_POP_FRONT: begin
            if (is_none) begin
               op_status = STAT_EMPTY;
            end else begin
               do_read = 1'b1;
               rd_addr = head_ff;
               head_in = head_inc;
               occ_in  = occ_ff - CNT_W'(1);
            end
         end
         KIND_POP_BACK: begin
            if (is_none) begin
               op_status = STAT_EMPTY;
            end else begin
               do_read = 1'b1;
               rd_addr = tail_dec;
               tail_in = tail_dec;
               occ_in  = occ_ff - CNT_W'(1);
            end
         end
         default: begin
            op_status = STAT_DONE;
         end
      endcase
   end

   cdq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.accept && do_write),
      .wr_addr (wr_addr),
      .wr_data (req.push_value),
      .rd_en   (cmd.accept && do_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign occ_in_wide = {{FILL_W{1'b0}}, occ_in};
   assign occ_ff_wide = {{FILL_W{1'b0}}, occ_ff};

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_direct) begin
         rsp_in.status       = op_status;
         rsp_in.popped_value = '0;
         rsp_in.fill_count   = occ_in_wide[FILL_W-1:0];
         rsp_in.is_empty     = (occ_in == '0);
         rsp_valid_in        = 1'b1;
      end else if (cmd.load_read) begin
         // indices and occupancy were already moved when the pop was taken
         rsp_in.status       = STAT_DONE;
         rsp_in.popped_value = rd_data;
         rsp_in.fill_count   = occ_ff_wide[FILL_W-1:0];
         rsp_in.is_empty     = is_none;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            occ_ff  <= occ_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign stat.needs_read = do_read;
   assign stat.out_valid  = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;

endmodule

// ===== rtl/circular_deque.sv =====
// circular_deque: top level of a fixed-capacity double-ended queue of 32-bit words
// depends on cdq_pkg, cdq_ctrl, cdq_dp (which holds cdq_ram)
//
// usage
//   - req channel: one beat asks for push back, push front, pop front or pop back;
//     push_value is only looked at on pushes
//   - rsp channel: exactly one beat per request with status (done, full, empty),
//     the popped word (zero unless a pop succeeded), fill count and empty flag
//   - a beat moves on a rising edge with valid high and stall low
// result path
//   - pushes and rejected operations: the result is loaded straight into the result
//     register, one item per cycle while the rsp side takes its results
//   - successful pops: the ring store has a registered read port, so the popped
//     word passes through the store's read register and then the result register;
//     a pop holds the request side in an extra state (ST_READ) while it is read
// reset
//   - synchronous, active high; clears indices, occupancy and the result valid flag
//   - the ring store needs no clearing: a pop only reads words pushed earlier
// back pressure
//   - the result register lets the next request in while a result still waits,
//     as long as the rsp side takes a beat in that cycle; while rsp_stall holds a
//     full result register, req_stall is raised and nothing moves
`timescale 1ns / 1ps

module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   ctrl_cmd_type cmd;   // accept / load result commands
   dp_stat_type  stat;  // pop needs store read, result register busy

   // sequencer: decides when a request beat is taken and when the result loads
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // indices, occupancy, ring store and the result register
   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

// ===== rtl/cdq_checker.sv =====
// cdq_checker: port-level assertions for circular_deque, bound to the top level
// depends on cdq_pkg and circular_deque
`timescale 1ns / 1ps

module cdq_checker
   import cdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result beat changed while stalled");

   // a push beat always yields a result in the next cycle
   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
         && (req.kind == KIND_PUSH_BACK || req.kind == KIND_PUSH_FRONT)
      |=> rsp_valid)
      else $error("push result missing one cycle after request beat");

   // rejected operations carry no popped word
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != STAT_DONE |-> rsp.popped_value == '0)
      else $error("rejected operation returned a nonzero word");

   // empty flag agrees with fill count and never comes with a full rejection
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.is_empty |-> rsp.fill_count == '0 && rsp.status != STAT_FULL)
      else $error("empty flag inconsistent with fill count or status");

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ===== bench/circular_deque_test.sv =====
// circular_deque_test: self-checking bench for the circular deque, one beat in, one beat out
// mirrors the deque in a scoreboard class and checks every result beat; depends on cdq_pkg and circular_deque
`timescale 1ns / 1ps

module circular_deque_test;
   import cdq_pkg::*;

   localparam int DEPTH        = DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS = 830;
   // last stretch of the run runs with no idling on either side
   localparam int QUIET_TAIL   = 120;
   localparam int PHASE_LEN    = 40;

   // mirror of the deque: keeps its own ring, indices and count, and queues
   // the result beat that each accepted request beat must produce
   class deque_mirror;
      logic [WORD_W-1:0] words [DEPTH];
      int unsigned       front_idx;
      int unsigned       back_idx;
      int unsigned       count;
      rsp_type           awaited_rsp [$];
      int unsigned       errors;
      int unsigned       n_push, n_pop, n_full, n_empty, n_checked;

      function new();
         front_idx = 0;
         back_idx  = 0;
         count     = 0;
         errors    = 0;
         n_push    = 0;
         n_pop     = 0;
         n_full    = 0;
         n_empty   = 0;
         n_checked = 0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("%0t ns mismatch: %s", $time, msg);
      endtask

      // apply one operation to the mirror and return the result it yields
      function rsp_type apply_op(req_type r);
         rsp_type res;
         res.status       = STAT_DONE;
         res.popped_value = '0;
         case (r.kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
               if (count >= DEPTH) begin
                  res.status = STAT_FULL;
                  n_full++;
               end else if (r.kind == KIND_PUSH_BACK) begin
                  words[back_idx] = r.push_value;
                  back_idx = (back_idx + 1) % DEPTH;
                  count++;
                  n_push++;
               end else begin
                  front_idx = (front_idx + DEPTH - 1) % DEPTH;
                  words[front_idx] = r.push_value;
                  count++;
                  n_push++;
               end
            end
            default: begin
               if (count == 0) begin
                  res.status = STAT_EMPTY;
                  n_empty++;
               end else if (r.kind == KIND_POP_FRONT) begin
                  res.popped_value = words[front_idx];
                  front_idx = (front_idx + 1) % DEPTH;
                  count--;
                  n_pop++;
               end else begin
                  back_idx = (back_idx + DEPTH - 1) % DEPTH;
                  res.popped_value = words[back_idx];
                  count--;
                  n_pop++;
               end
            end
         endcase
         res.fill_count = count[FILL_W-1:0];
         res.is_empty   = (count == 0);
         return res;
      endfunction

      function void note_request(req_type r);
         awaited_rsp.push_back(apply_op(r));
      endfunction

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report("result beat with no request waiting on it");
            return;
         end
         want = awaited_rsp.pop_front();
         n_checked++;
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.popped_value !== want.popped_value)
            report($sformatf("popped_value got %0d want %0d",
                             got.popped_value, want.popped_value));
         if (got.fill_count !== want.fill_count)
            report($sformatf("fill_count got %0d want %0d", got.fill_count, want.fill_count));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // knobs for the result side, written with nonblocking assignments
   logic    stall_on  = 1'b1;
   logic    quiet     = 1'b0;
   int      stall_left = 0;
   // idling knob for the request side, used only by the driving process
   bit      idle_on   = 1'b1;

   deque_mirror board = new();

   circular_deque #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial forever #5 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("run timed out, %0d results still awaited", board.awaited_rsp.size());
      $display("== FAIL ==");
      $finish;
   end

   // beat monitor: values seen here are the ones from before the edge;
   // result first, since a result never belongs to a request of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp);
         if (req_valid && !req_stall)
            board.note_request(req);
      end
   end

   // result side stalls in bursts of random length
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // idle gap ahead of the next request beat
   function automatic int pick_gap();
      if (quiet || !idle_on)
         return 0;
      if ($urandom_range(0, 5) == 0)
         return $urandom_range(1, 15);
      return 0;
   endfunction

   // mostly random words, with the extremes mixed in
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // hold one request beat until the block takes it; valid stays high when
   // the next beat follows with no gap
   task automatic send_op(input kind_type k, input logic [WORD_W-1:0] v, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{kind: k, push_value: v};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int unsigned push_pct;
      kind_type    k;
      push_pct = 50;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops at both ends
      send_op(KIND_POP_FRONT, 32'hffff_ffff, pick_gap());
      send_op(KIND_POP_BACK, 32'h1234_5678, pick_gap());
      // extremes in at both ends, then out again from the same ends
      send_op(KIND_PUSH_BACK, 32'h7fff_ffff, pick_gap());
      send_op(KIND_PUSH_FRONT, 32'h8000_0000, pick_gap());
      send_op(KIND_POP_BACK, 32'h0, pick_gap());
      send_op(KIND_POP_FRONT, 32'h0, pick_gap());
      // fill from both ends; the front index wraps below zero on the way
      for (int j = 0; j < DEPTH; j++) begin
         if (j[0])
            send_op(KIND_PUSH_FRONT, 32'h8000_0000 + j, pick_gap());
         else
            send_op(KIND_PUSH_BACK, 32'h7fff_ffff - j, pick_gap());
      end
      // pushes into a full deque at both ends, then drain one from each end
      send_op(KIND_PUSH_BACK, 32'hdead_beef, pick_gap());
      send_op(KIND_PUSH_FRONT, 32'h5555_aaaa, pick_gap());
      send_op(KIND_POP_FRONT, 32'h0, pick_gap());
      send_op(KIND_POP_BACK, 32'h0, pick_gap());

      // random part: phases lean toward pushes or pops so the deque
      // swings between full and empty and the indices wrap many times
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) begin
            case ($urandom_range(0, 3))
               0:       push_pct = 20;
               1:       push_pct = 80;
               2:       push_pct = 65;
               default: push_pct = 50;
            endcase
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on <= ($urandom_range(0, 3) != 0);
         end
         // raised one item ahead so both sides are already quiet for the tail
         if (i == RANDOM_ITEMS - QUIET_TAIL - 1)
            quiet <= 1'b1;
         if ($urandom_range(0, 99) < push_pct)
            k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         else
            k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
         send_op(k, pick_word(), pick_gap());
      end
      req_valid <= 1'b0;

      // drain: wait for every awaited result, then check that none is left
      while (board.awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.awaited_rsp.size() != 0)
         board.report($sformatf("%0d results never arrived", board.awaited_rsp.size()));

      $display("checked %0d results: %0d words stored, %0d removed",
               board.n_checked, board.n_push, board.n_pop);
      $display("refused %0d pushes when full and %0d pops when empty, %0d mismatches",
               board.n_full, board.n_empty, board.errors);
      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque.sv
rtl/cdq_checker.sv
bench/circular_deque_test.sv
